// ===== rtl/core/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and codes for the round-robin task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package rrts_pkg;
	// ring size; live_tasks and the task count are sized for it
	localparam int MAX_TASKS = 16;

	localparam logic [2:0] K_ADD = 3'd0;
	localparam logic [2:0] K_KILL = 3'd1;
	localparam logic [2:0] K_START = 3'd2;
	localparam logic [2:0] K_SCHED = 3'd3;
	localparam logic [2:0] K_SWITCH = 3'd4;
	localparam logic [2:0] K_SETST = 3'd5;
	localparam logic [2:0] K_QUERY = 3'd6;
	localparam logic [2:0] K_NOP = 3'd7;

	localparam logic [2:0] RC_OK = 3'd0;
	localparam logic [2:0] RC_NOT_STARTED = 3'd1;
	localparam logic [2:0] RC_NO_READY = 3'd2;
	localparam logic [2:0] RC_NOT_FOUND = 3'd3;
	localparam logic [2:0] RC_FULL = 3'd4;
	localparam logic [2:0] RC_EMPTY = 3'd5;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ACTIVE = 3'd1;
	localparam logic [2:0] ST_SEM = 3'd2;
	localparam logic [2:0] ST_SEM_UNTIL = 3'd3;
	localparam logic [2:0] ST_DELAY = 3'd4;

	localparam logic [1:0] CFG_HIGH_Q = 2'd0;
	localparam logic [1:0] CFG_NORMAL_Q = 2'd1;
	localparam logic [1:0] CFG_LOW_Q = 2'd2;
	localparam logic [1:0] CFG_FIRST_ID = 2'd3;

	function automatic logic is_blocked(input logic [2:0] st);
		return (st == ST_SEM) || (st == ST_SEM_UNTIL) || (st == ST_DELAY);
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/round_robin_task_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit
// Ring of task entries walked by one sequencer, one entry per cycle.
// ----------------------------------------------------------------------------
// Use: drive kind/task_id/priority_req/new_status with start high while busy
// is low; that beat is taken. busy then stays high until the result beat,
// shown for one cycle with done high. The receiver cannot hold it off.
// Operation: a decode step, then ring walks of one entry per cycle:
// add walks the id run (up to live_tasks+1), the free slot search (up to
// MAX_TASKS) and the tail walk (up to live_tasks); kill walks to the target
// then, if the target is the head, to the tail; schedule up to MAX_TASKS+2
// steps; lookups up to live_tasks+1. busy is low in the result cycle, so a
// new beat can be taken there.
// Configuration: cfg_we/cfg_index/cfg_data write a quantum or the id base
// at once; write only while idle.
// Reset: the ring is empty, not started, registers at 10/8/6/1. No clearing
// pass: entry valid bits sit in flip-flops; the other entry fields are
// undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
module round_robin_task_scheduler_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [2:0] kind,
	input wire logic [7:0] task_id,
	input wire logic [1:0] priority_req,
	input wire logic [2:0] new_status,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [7:0] cfg_data,
	output logic done,
	output logic [2:0] result_code,
	output logic [7:0] chosen_id,
	output logic [7:0] quantum,
	output logic [2:0] task_state,
	output logic [1:0] task_prio,
	output logic [4:0] live_tasks
);
	localparam int SW = (rrts_pkg::MAX_TASKS > 1) ? $clog2(rrts_pkg::MAX_TASKS) : 1;
	localparam int CW = $clog2(rrts_pkg::MAX_TASKS + 3);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_IDRUN, S_FREE, S_TAIL, S_KFIND, S_SCHED,
		S_FIND, S_DONE
	} state_t;

	// entry table: combinational reads, at cur_q and also at head_q, run_q and tgt_q
	logic [7:0] ent_id [rrts_pkg::MAX_TASKS];
	logic [1:0] ent_prio [rrts_pkg::MAX_TASKS];
	logic [2:0] ent_st [rrts_pkg::MAX_TASKS];
	logic [SW-1:0] ent_nx [rrts_pkg::MAX_TASKS];
	logic [rrts_pkg::MAX_TASKS-1:0] valid_q;

	state_t state_q;
	logic [SW-1:0] head_q, run_q, cur_q, prev_q, tgt_q;
	logic has_prev_q, started_q;
	logic [CW-1:0] cnt_q;
	logic [7:0] pid_q;
	logic [2:0] kind_q, nst_q;
	logic [7:0] tid_q;
	logic [1:0] preq_q;
	logic [7:0] hq_q, nq_q, lq_q, fid_q;
	logic [4:0] total_q;

	logic [7:0] c_id;
	logic [2:0] c_st;
	logic [SW-1:0] c_nx;
	assign c_id = ent_id[cur_q];
	assign c_st = ent_st[cur_q];
	assign c_nx = ent_nx[cur_q];

	function automatic logic [7:0] qsel(input logic [1:0] p, input logic [7:0] h,
		input logic [7:0] n, input logic [7:0] l);
		priority if (p == 2'd2) return h;
		else if (p == 2'd1) return n;
		else return l;
	endfunction

	assign busy = (state_q != S_IDLE);
	assign live_tasks = total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hq_q <= 8'd10; nq_q <= 8'd8; lq_q <= 8'd6; fid_q <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rrts_pkg::CFG_HIGH_Q: hq_q <= cfg_data;
				rrts_pkg::CFG_NORMAL_Q: nq_q <= cfg_data;
				rrts_pkg::CFG_LOW_Q: lq_q <= cfg_data;
				rrts_pkg::CFG_FIRST_ID: fid_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// error beat: running id when started and non-empty
	logic [7:0] run_id;
	assign run_id = (started_q && total_q != 5'd0) ? ent_id[run_q] : 8'd0;

	// decode of the latched command
	state_t d_next;
	logic [2:0] d_rc;
	logic [SW-1:0] d_cur;
	logic d_start;

	always_comb begin
		d_rc = rrts_pkg::RC_OK; d_next = S_DONE; d_cur = head_q; d_start = 1'b0;
		unique case (kind_q)
			rrts_pkg::K_ADD: begin
				if (total_q >= 5'(rrts_pkg::MAX_TASKS)) d_rc = rrts_pkg::RC_FULL;
				else d_next = S_IDRUN;
			end
			rrts_pkg::K_KILL, rrts_pkg::K_SETST, rrts_pkg::K_QUERY: begin
				if (total_q == 5'd0) d_rc = rrts_pkg::RC_EMPTY;
				else if (kind_q == rrts_pkg::K_KILL) d_next = S_KFIND;
				else d_next = S_FIND;
			end
			rrts_pkg::K_START: begin
				if (total_q == 5'd0) d_rc = rrts_pkg::RC_EMPTY;
				else d_start = 1'b1;
			end
			rrts_pkg::K_SCHED, rrts_pkg::K_SWITCH: begin
				if (!started_q) d_rc = rrts_pkg::RC_NOT_STARTED;
				else if (total_q == 5'd0) d_rc = rrts_pkg::RC_EMPTY;
				else if (kind_q == rrts_pkg::K_SCHED) begin
					d_cur = ent_nx[run_q]; d_next = S_SCHED;
				end else d_next = S_FIND;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; valid_q <= '0; head_q <= '0; run_q <= '0;
			started_q <= 1'b0; total_q <= '0; done <= 1'b0;
			cur_q <= '0; prev_q <= '0; tgt_q <= '0; has_prev_q <= 1'b0;
			cnt_q <= '0; pid_q <= '0; kind_q <= '0; tid_q <= '0;
			preq_q <= '0; nst_q <= '0;
			result_code <= '0; chosen_id <= '0; quantum <= '0;
			task_state <= '0; task_prio <= '0;
		end else begin
			done <= (state_q == S_DONE);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q <= kind; tid_q <= task_id; preq_q <= priority_req;
						nst_q <= new_status; state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					result_code <= d_rc;
					chosen_id <= (d_rc != rrts_pkg::RC_OK) ? run_id :
						(d_start ? ent_id[head_q] : 8'd0);
					quantum <= d_start ? qsel(ent_prio[head_q], hq_q, nq_q, lq_q) : 8'd0;
					task_state <= d_start ? rrts_pkg::ST_ACTIVE : rrts_pkg::ST_IDLE;
					task_prio <= d_start ? ent_prio[head_q] : 2'd0;
					cur_q <= d_cur; cnt_q <= '0; has_prev_q <= 1'b0;
					pid_q <= fid_q; state_q <= d_next;
					if (d_start) begin
						run_q <= head_q; started_q <= 1'b1;
						ent_st[head_q] <= rrts_pkg::ST_ACTIVE;
					end
				end
				S_IDRUN: begin
					// leading run of sequential ids from the head
					if (cnt_q >= CW'(total_q) || c_id != pid_q) begin
						cur_q <= '0; state_q <= S_FREE;
					end else begin
						pid_q <= pid_q + 8'd1; cur_q <= c_nx; cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FREE: begin
					if (!valid_q[cur_q]) begin
						tgt_q <= cur_q;
						valid_q[cur_q] <= 1'b1; ent_id[cur_q] <= pid_q;
						ent_prio[cur_q] <= preq_q; ent_st[cur_q] <= rrts_pkg::ST_IDLE;
						chosen_id <= pid_q; task_prio <= preq_q;
						if (total_q == 5'd0) begin
							head_q <= cur_q; ent_nx[cur_q] <= cur_q;
							total_q <= total_q + 5'd1; state_q <= S_DONE;
						end else begin
							ent_nx[cur_q] <= head_q; cur_q <= head_q; cnt_q <= '0;
							state_q <= S_TAIL;
						end
					end else if (cur_q == SW'(rrts_pkg::MAX_TASKS - 1)) begin
						result_code <= rrts_pkg::RC_FULL; chosen_id <= run_id;
						state_q <= S_DONE;
					end else cur_q <= cur_q + 1'b1;
				end
				S_TAIL: begin
					// tail: entry whose link returns to the head
					if (c_nx == head_q || cnt_q == CW'(rrts_pkg::MAX_TASKS - 1)) begin
						if (kind_q == rrts_pkg::K_ADD) begin
							ent_nx[cur_q] <= tgt_q; total_q <= total_q + 5'd1;
						end else begin
							head_q <= ent_nx[tgt_q]; ent_nx[cur_q] <= ent_nx[tgt_q];
							valid_q[tgt_q] <= 1'b0; total_q <= total_q - 5'd1;
						end
						state_q <= S_DONE;
					end else begin
						cur_q <= c_nx; cnt_q <= cnt_q + 1'b1;
					end
				end
				S_KFIND: begin
					if (cnt_q >= CW'(total_q)) begin
						result_code <= rrts_pkg::RC_NOT_FOUND; chosen_id <= run_id;
						state_q <= S_DONE;
					end else if (c_id == tid_q) begin
						chosen_id <= c_id; task_state <= c_st; task_prio <= ent_prio[cur_q];
						if (has_prev_q) begin
							ent_nx[prev_q] <= c_nx; valid_q[cur_q] <= 1'b0;
							total_q <= total_q - 5'd1; state_q <= S_DONE;
						end else if (total_q > 5'd1) begin
							tgt_q <= cur_q; cnt_q <= '0; state_q <= S_TAIL;
						end else begin
							valid_q[cur_q] <= 1'b0; total_q <= total_q - 5'd1;
							state_q <= S_DONE;
						end
					end else begin
						prev_q <= cur_q; has_prev_q <= 1'b1; cur_q <= c_nx;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIND: begin
					if (cnt_q >= CW'(total_q)) begin
						result_code <= rrts_pkg::RC_NOT_FOUND; chosen_id <= run_id;
						state_q <= S_DONE;
					end else if (c_id == tid_q) begin
						chosen_id <= c_id; task_prio <= ent_prio[cur_q];
						state_q <= S_DONE;
						if (kind_q == rrts_pkg::K_SWITCH) begin
							quantum <= qsel(ent_prio[run_q], hq_q, nq_q, lq_q);
							// target set active; outgoing idled if still active and not the target,
							// so a switch to itself is not idled and just ends up active
							ent_st[cur_q] <= rrts_pkg::ST_ACTIVE;
							task_state <= rrts_pkg::ST_ACTIVE;
							if (cur_q != run_q && ent_st[run_q] == rrts_pkg::ST_ACTIVE)
								ent_st[run_q] <= rrts_pkg::ST_IDLE;
							run_q <= cur_q;
						end else if (kind_q == rrts_pkg::K_SETST) begin
							ent_st[cur_q] <= nst_q; task_state <= nst_q;
						end else task_state <= c_st;
					end else begin
						cur_q <= c_nx; cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SCHED: begin
					if (!rrts_pkg::is_blocked(c_st)) begin
						quantum <= qsel(ent_prio[run_q], hq_q, nq_q, lq_q);
						chosen_id <= c_id; task_prio <= ent_prio[cur_q];
						if (cur_q == run_q) begin
							// outgoing idled first, then idle becomes active
							if (c_st == rrts_pkg::ST_ACTIVE || c_st == rrts_pkg::ST_IDLE) begin
								ent_st[cur_q] <= rrts_pkg::ST_ACTIVE;
								task_state <= rrts_pkg::ST_ACTIVE;
							end else task_state <= c_st;
						end else begin
							if (ent_st[run_q] == rrts_pkg::ST_ACTIVE)
								ent_st[run_q] <= rrts_pkg::ST_IDLE;
							if (c_st == rrts_pkg::ST_IDLE) begin
								ent_st[cur_q] <= rrts_pkg::ST_ACTIVE;
								task_state <= rrts_pkg::ST_ACTIVE;
							end else task_state <= c_st;
						end
						run_q <= cur_q; state_q <= S_DONE;
					end else if (c_id == ent_id[run_q] ||
						cnt_q == CW'(rrts_pkg::MAX_TASKS + 1)) begin
						result_code <= rrts_pkg::RC_NO_READY; chosen_id <= run_id;
						state_q <= S_DONE;
					end else begin
						cur_q <= c_nx; cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/rrts_checker.sv =====
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks on the scheduler's command and result beats.
// ----------------------------------------------------------------------------
`default_nettype none
module rrts_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic [2:0] result_code,
	input wire logic [4:0] live_tasks
);
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("no busy after take");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result beat while busy");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beat repeated");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result_code <= 3'd5) else $error("bad result code");
	a_live: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !done |=> $stable(live_tasks) || busy)
		else $error("live count moved while idle");
endmodule

bind round_robin_task_scheduler_unit rrts_checker u_rrts_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.result_code(result_code), .live_tasks(live_tasks)
);
`default_nettype wire
